// ----- rtl/core/fbc_pkg.sv -----
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared types and constants for the frame bounding-box crop block.
// ----------------------------------------------------------------------------
package fbc_pkg;

    // Frame store geometry.
    localparam int MAX_ROWS    = 256;
    localparam int MAX_COLS    = 1024;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int HGT_W  = ROW_W + 1;
    localparam int WID_W  = COL_W + 1;

    // Fixed field widths of the ports.
    localparam int PIX_W      = 8;
    localparam int IN_ROW_W   = 8;
    localparam int IN_COL_W   = 10;
    localparam int OUT_ROW_W  = 8;
    localparam int OUT_COL_W  = 10;
    localparam int OUT_HGT_W  = 9;
    localparam int OUT_WID_W  = 11;
    localparam int CFG_H_W    = 9;
    localparam int CFG_W_W    = 11;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_H_W-1:0] USED_H_RESET = CFG_H_W'(256);
    localparam logic [CFG_W_W-1:0] USED_W_RESET = CFG_W_W'(1024);

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_FIND  = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    typedef enum logic {
        CFG_USED_HEIGHT = 1'b0,
        CFG_USED_WIDTH  = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

    // Control word from the sequencer to the box accumulator.
    typedef struct packed {
        logic             restart;
        logic             valid;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_acc_ctl;

    // Edges gathered by the accumulator.
    typedef struct packed {
        logic             seen;
        logic [ROW_W-1:0] top;
        logic [ROW_W-1:0] bottom;
        logic [COL_W-1:0] left;
        logic [COL_W-1:0] right;
    } t_box;

endpackage

// ----- rtl/core/fbc_ram.sv -----
// ----------------------------------------------------------------------------
// fbc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fbc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/fbc_box_acc.sv -----
// ----------------------------------------------------------------------------
// fbc_box_acc
// Gathers the edges of the nonzero pixels as the scan streams them past.
// ----------------------------------------------------------------------------
module fbc_box_acc (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fbc_pkg::t_acc_ctl          i_ctl,
    input  logic [fbc_pkg::PIX_W-1:0]  i_pixel,
    output fbc_pkg::t_box              o_box
);

    logic                      r_seen;
    logic [fbc_pkg::ROW_W-1:0] r_top;
    logic [fbc_pkg::ROW_W-1:0] r_bottom;
    logic [fbc_pkg::COL_W-1:0] r_left;
    logic [fbc_pkg::COL_W-1:0] r_right;
    logic                      hit;

    assign hit = i_ctl.valid && (i_pixel != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (i_ctl.restart) begin
            r_seen <= 1'b0;
        end else if (hit) begin
            r_seen <= 1'b1;
        end
    end

    // The scan runs in raster order, so the first hit fixes the top row
    // and every later hit is on the bottom row so far.
    always_ff @(posedge i_clk) begin
        if (hit) begin
            r_bottom <= i_ctl.row;
            if (!r_seen) begin
                r_top   <= i_ctl.row;
                r_left  <= i_ctl.col;
                r_right <= i_ctl.col;
            end else begin
                if (i_ctl.col < r_left) begin
                    r_left <= i_ctl.col;
                end
                if (i_ctl.col > r_right) begin
                    r_right <= i_ctl.col;
                end
            end
        end
    end

    assign o_box.seen   = r_seen;
    assign o_box.top    = r_top;
    assign o_box.bottom = r_bottom;
    assign o_box.left   = r_left;
    assign o_box.right  = r_right;

endmodule

// ----- rtl/core/frame_bounding_box_crop.sv -----
// ----------------------------------------------------------------------------
// frame_bounding_box_crop
// Frame store with nonzero bounding-box search and cropped pixel read.
// ----------------------------------------------------------------------------
// Usage: a request word is taken when i_start is high and o_busy is low.
// i_req_type selects a pixel write, a store clear, a box search or a read
// at a row and column offset from the last box found. Every request gives
// one result word, shown for one cycle with o_done high; the box fields
// always show the box held after the request.
// Writes and reads give their result in the cycle after the request and
// o_busy stays low, so they run one per cycle.
// A box search reads the store one pixel per cycle over used_height rows
// by used_width columns, clamped to the store, via the single read port.
// A clear writes one zero per cycle over all MAX_ROWS * MAX_COLS words of
// the store. After reset the same clearing pass runs first with o_busy
// high and no result.
// The receiver cannot stall: o_done is a strobe. Configuration writes on
// i_cfg_we are taken at any time and are meant for idle periods only.
// ----------------------------------------------------------------------------
module frame_bounding_box_crop (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [fbc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [1:0]                        i_req_type,
    input  logic [fbc_pkg::IN_ROW_W-1:0]      i_pix_row,
    input  logic [fbc_pkg::IN_COL_W-1:0]      i_pix_col,
    input  logic [fbc_pkg::PIX_W-1:0]         i_pix_value,
    output logic                              o_done,
    output logic [fbc_pkg::OUT_ROW_W-1:0]     o_box_top,
    output logic [fbc_pkg::OUT_ROW_W-1:0]     o_box_bottom,
    output logic [fbc_pkg::OUT_COL_W-1:0]     o_box_left,
    output logic [fbc_pkg::OUT_COL_W-1:0]     o_box_right,
    output logic [fbc_pkg::OUT_HGT_W-1:0]     o_box_height,
    output logic [fbc_pkg::OUT_WID_W-1:0]     o_box_width,
    output logic [fbc_pkg::PIX_W-1:0]         o_read_pixel,
    output logic                              o_outside_box
);

    localparam logic [fbc_pkg::ADDR_W-1:0] CLR_LAST =
        fbc_pkg::ADDR_W'(fbc_pkg::STORE_DEPTH - 1);
    localparam logic [fbc_pkg::ADDR_W-1:0] ROW_STEP =
        fbc_pkg::ADDR_W'(fbc_pkg::MAX_COLS);

    fbc_pkg::t_state r_state, n_state;
    fbc_pkg::t_req   req;

    logic                          r_done, n_done;
    logic                          r_pix_en, n_pix_en;
    logic                          r_outside, n_outside;
    logic                          r_clr_report, n_clr_report;
    logic [fbc_pkg::ADDR_W-1:0]    r_clr_addr, n_clr_addr;
    logic [fbc_pkg::ROW_W-1:0]     r_row, n_row;
    logic [fbc_pkg::COL_W-1:0]     r_col, n_col;
    logic [fbc_pkg::ADDR_W-1:0]    r_base, n_base;
    logic [fbc_pkg::ROW_W-1:0]     r_rows_last, n_rows_last;
    logic [fbc_pkg::COL_W-1:0]     r_cols_last, n_cols_last;
    logic                          r_tag_valid, n_tag_valid;
    logic [fbc_pkg::ROW_W-1:0]     r_tag_row, n_tag_row;
    logic [fbc_pkg::COL_W-1:0]     r_tag_col, n_tag_col;
    logic [fbc_pkg::ROW_W-1:0]     r_top, n_top;
    logic [fbc_pkg::ROW_W-1:0]     r_bottom, n_bottom;
    logic [fbc_pkg::COL_W-1:0]     r_left, n_left;
    logic [fbc_pkg::COL_W-1:0]     r_right, n_right;
    logic [fbc_pkg::CFG_H_W-1:0]   r_used_h;
    logic [fbc_pkg::CFG_W_W-1:0]   r_used_w;

    logic                          ram_we;
    logic [fbc_pkg::ADDR_W-1:0]    ram_waddr;
    logic [fbc_pkg::PIX_W-1:0]     ram_wdata;
    logic                          ram_re;
    logic [fbc_pkg::ADDR_W-1:0]    ram_raddr;
    logic [fbc_pkg::PIX_W-1:0]     ram_rdata;
    logic                          acc_restart;
    fbc_pkg::t_acc_ctl             acc_ctl;
    fbc_pkg::t_box                 acc_box;

    logic [fbc_pkg::HGT_W-1:0]     box_hgt;
    logic [fbc_pkg::WID_W-1:0]     box_wid;
    logic [31:0]                   rows_clamp;
    logic [31:0]                   cols_clamp;
    logic [31:0]                   rd_row_abs;
    logic [31:0]                   rd_col_abs;
    logic                          rd_in_box;
    logic                          rd_in_store;
    logic [fbc_pkg::ADDR_W-1:0]    rd_addr;
    logic                          wr_in_store;
    logic [fbc_pkg::ADDR_W-1:0]    wr_addr;

    assign req    = fbc_pkg::t_req'(i_req_type);
    assign o_busy = (r_state != fbc_pkg::ST_IDLE);

    // Box size from the held edges.
    assign box_hgt = fbc_pkg::HGT_W'(r_bottom) - fbc_pkg::HGT_W'(r_top)
                   + fbc_pkg::HGT_W'(1);
    assign box_wid = fbc_pkg::WID_W'(r_right) - fbc_pkg::WID_W'(r_left)
                   + fbc_pkg::WID_W'(1);

    // Scan limits, clamped to the store.
    assign rows_clamp = (32'(r_used_h) > 32'(fbc_pkg::MAX_ROWS)) ?
                        32'(fbc_pkg::MAX_ROWS) : 32'(r_used_h);
    assign cols_clamp = (32'(r_used_w) > 32'(fbc_pkg::MAX_COLS)) ?
                        32'(fbc_pkg::MAX_COLS) : 32'(r_used_w);

    // Cropped read address.
    assign rd_row_abs  = 32'(r_top) + 32'(i_pix_row);
    assign rd_col_abs  = 32'(r_left) + 32'(i_pix_col);
    assign rd_in_box   = (32'(i_pix_row) < 32'(box_hgt)) &&
                         (32'(i_pix_col) < 32'(box_wid));
    assign rd_in_store = (rd_row_abs < 32'(fbc_pkg::MAX_ROWS)) &&
                         (rd_col_abs < 32'(fbc_pkg::MAX_COLS));
    assign rd_addr     = fbc_pkg::ADDR_W'(rd_row_abs * 32'(fbc_pkg::MAX_COLS)
                         + rd_col_abs);

    // Pixel write address.
    assign wr_in_store = (32'(i_pix_row) < 32'(fbc_pkg::MAX_ROWS)) &&
                         (32'(i_pix_col) < 32'(fbc_pkg::MAX_COLS));
    assign wr_addr     = fbc_pkg::ADDR_W'(32'(i_pix_row) * 32'(fbc_pkg::MAX_COLS)
                         + 32'(i_pix_col));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_h <= fbc_pkg::USED_H_RESET;
            r_used_w <= fbc_pkg::USED_W_RESET;
        end else if (i_cfg_we) begin
            case (fbc_pkg::t_cfg_idx'(i_cfg_idx))
                fbc_pkg::CFG_USED_HEIGHT: r_used_h <= i_cfg_data[fbc_pkg::CFG_H_W-1:0];
                fbc_pkg::CFG_USED_WIDTH:  r_used_w <= i_cfg_data[fbc_pkg::CFG_W_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fbc_pkg::ST_CLEAR;
            r_done       <= 1'b0;
            r_pix_en     <= 1'b0;
            r_outside    <= 1'b0;
            r_clr_report <= 1'b0;
            r_clr_addr   <= '0;
            r_tag_valid  <= 1'b0;
            r_top        <= '0;
            r_bottom     <= '0;
            r_left       <= '0;
            r_right      <= '0;
        end else begin
            r_state      <= n_state;
            r_done       <= n_done;
            r_pix_en     <= n_pix_en;
            r_outside    <= n_outside;
            r_clr_report <= n_clr_report;
            r_clr_addr   <= n_clr_addr;
            r_tag_valid  <= n_tag_valid;
            r_top        <= n_top;
            r_bottom     <= n_bottom;
            r_left       <= n_left;
            r_right      <= n_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row       <= n_row;
        r_col       <= n_col;
        r_base      <= n_base;
        r_rows_last <= n_rows_last;
        r_cols_last <= n_cols_last;
        r_tag_row   <= n_tag_row;
        r_tag_col   <= n_tag_col;
    end

    always_comb begin
        n_state      = r_state;
        n_done       = 1'b0;
        n_pix_en     = 1'b0;
        n_outside    = 1'b0;
        n_clr_report = r_clr_report;
        n_clr_addr   = r_clr_addr;
        n_row        = r_row;
        n_col        = r_col;
        n_base       = r_base;
        n_rows_last  = r_rows_last;
        n_cols_last  = r_cols_last;
        n_tag_valid  = 1'b0;
        n_tag_row    = r_row;
        n_tag_col    = r_col;
        n_top        = r_top;
        n_bottom     = r_bottom;
        n_left       = r_left;
        n_right      = r_right;
        ram_we       = 1'b0;
        ram_waddr    = wr_addr;
        ram_wdata    = i_pix_value;
        ram_re       = 1'b0;
        ram_raddr    = rd_addr;
        acc_restart  = 1'b0;

        case (r_state)
            fbc_pkg::ST_IDLE: begin
                if (i_start) begin
                    case (req)
                        fbc_pkg::REQ_WRITE: begin
                            ram_we = wr_in_store;
                            n_done = 1'b1;
                        end
                        fbc_pkg::REQ_READ: begin
                            ram_re    = 1'b1;
                            n_pix_en  = rd_in_box && rd_in_store;
                            n_outside = !rd_in_box;
                            n_done    = 1'b1;
                        end
                        fbc_pkg::REQ_CLEAR: begin
                            n_state      = fbc_pkg::ST_CLEAR;
                            n_clr_addr   = '0;
                            n_clr_report = 1'b1;
                        end
                        fbc_pkg::REQ_FIND: begin
                            if (r_used_h == '0 || r_used_w == '0) begin
                                // Refused search: the box stays as it was.
                                n_done = 1'b1;
                            end else begin
                                n_state     = fbc_pkg::ST_SCAN;
                                n_row       = '0;
                                n_col       = '0;
                                n_base      = '0;
                                n_rows_last = fbc_pkg::ROW_W'(rows_clamp - 32'd1);
                                n_cols_last = fbc_pkg::COL_W'(cols_clamp - 32'd1);
                                acc_restart = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            fbc_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                if (r_clr_addr == CLR_LAST) begin
                    n_state      = fbc_pkg::ST_IDLE;
                    n_done       = r_clr_report;
                    n_clr_report = 1'b0;
                end else begin
                    n_clr_addr = r_clr_addr + fbc_pkg::ADDR_W'(1);
                end
            end
            fbc_pkg::ST_SCAN: begin
                // The pixel coordinates are registered beside the read.
                ram_re      = 1'b1;
                ram_raddr   = r_base + fbc_pkg::ADDR_W'(r_col);
                n_tag_valid = 1'b1;
                if (r_col == r_cols_last) begin
                    n_col = '0;
                    if (r_row == r_rows_last) begin
                        n_state = fbc_pkg::ST_DRAIN;
                    end else begin
                        n_row  = r_row + fbc_pkg::ROW_W'(1);
                        n_base = r_base + ROW_STEP;
                    end
                end else begin
                    n_col = r_col + fbc_pkg::COL_W'(1);
                end
            end
            fbc_pkg::ST_DRAIN: begin
                n_state = fbc_pkg::ST_COMMIT;
            end
            fbc_pkg::ST_COMMIT: begin
                // An empty region leaves every edge at zero.
                if (acc_box.seen) begin
                    n_top    = acc_box.top;
                    n_bottom = acc_box.bottom;
                    n_left   = acc_box.left;
                    n_right  = acc_box.right;
                end else begin
                    n_top    = '0;
                    n_bottom = '0;
                    n_left   = '0;
                    n_right  = '0;
                end
                n_done  = 1'b1;
                n_state = fbc_pkg::ST_IDLE;
            end
            default: begin
                n_state = fbc_pkg::ST_IDLE;
            end
        endcase
    end

    assign acc_ctl.restart = acc_restart;
    assign acc_ctl.valid   = r_tag_valid;
    assign acc_ctl.row     = r_tag_row;
    assign acc_ctl.col     = r_tag_col;

    fbc_ram #(
        .DEPTH (fbc_pkg::STORE_DEPTH),
        .WIDTH (fbc_pkg::PIX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fbc_box_acc u_box_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (acc_ctl),
        .i_pixel (ram_rdata),
        .o_box   (acc_box)
    );

    assign o_done        = r_done;
    assign o_box_top     = fbc_pkg::OUT_ROW_W'(r_top);
    assign o_box_bottom  = fbc_pkg::OUT_ROW_W'(r_bottom);
    assign o_box_left    = fbc_pkg::OUT_COL_W'(r_left);
    assign o_box_right   = fbc_pkg::OUT_COL_W'(r_right);
    assign o_box_height  = fbc_pkg::OUT_HGT_W'(box_hgt);
    assign o_box_width   = fbc_pkg::OUT_WID_W'(box_wid);
    assign o_read_pixel  = r_pix_en ? ram_rdata : '0;
    assign o_outside_box = r_outside;

endmodule
